>>> rtl/debug_symbol_table_lookup_defines.svh
// ----------------------------------------------------------------------------
// debug_symbol_table_lookup_defines
// Assertion macros for the symbol table lookup controller.
// ----------------------------------------------------------------------------
`ifndef DEBUG_SYMBOL_TABLE_LOOKUP_DEFINES_SVH
`define DEBUG_SYMBOL_TABLE_LOOKUP_DEFINES_SVH

`ifndef SYNTHESIS
// checked only out of reset
`define DSTL_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// checked at every edge, reset included
`define DSTL_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DSTL_ASSERT(lbl, prop, msg)
`define DSTL_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

>>> rtl/dstl_pkg.sv
// ----------------------------------------------------------------------------
// dstl_pkg
// Types and constants shared by the symbol table lookup controller and datapath.
// ----------------------------------------------------------------------------
package dstl_pkg;

	localparam logic [7:0] TY_FILE  = 8'h64;
	localparam logic [7:0] TY_FUNC  = 8'h24;
	localparam logic [7:0] TY_LINE  = 8'h44;
	localparam logic [7:0] TY_INCL  = 8'h84;
	localparam logic [7:0] TY_PARAM = 8'ha0;

	localparam logic CMD_WRITE  = 1'b0;
	localparam logic CMD_LOOKUP = 1'b1;

	localparam logic [1:0] REG_ENTRY_COUNT   = 2'd0;
	localparam logic [1:0] REG_STRING_SIZE   = 2'd1;
	localparam logic [1:0] REG_STRINGS_VALID = 2'd2;

	typedef enum logic [1:0] {
		LS_FOUND       = 2'd0,
		LS_BAD_STRINGS = 2'd1,
		LS_NO_FILE     = 2'd2,
		LS_NO_LINE     = 2'd3
	} lookup_status_t;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_WRITE,
		OP_LOAD,
		OP_BAD,
		OP_NOFILE,
		OP_NOLINE,
		OP_FILE_INIT,
		OP_FUNC_INIT,
		OP_FUNC_RD,
		OP_FUNC_SET,
		OP_NOFUNC,
		OP_LINE_RD,
		OP_LINE_SET,
		OP_B_INIT,
		OP_B_MID,
		OP_B_MISS,
		OP_RD_M,
		OP_DEC_M,
		OP_B_HIT,
		OP_B_NOHIT,
		OP_K_HI,
		OP_RD_K,
		OP_DEC_K,
		OP_K_DONE,
		OP_FILE_SET,
		OP_ARG_INIT,
		OP_ARG_INC,
		OP_EMIT
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
	} dp_cmd_t;

	typedef struct packed {
		logic bad_strings;
		logic l_le_r;
		logic m_lt_l;
		logic ty_hit;
		logic hit;
		logic k_gt_lo;
		logic lo_zero;
		logic lo_le_hi;
		logic k_ge_lfile;
		logic file_mark;
		logic fun_lt;
		logic k_lt_rfun;
		logic is_param;
	} dp_status_t;

endpackage

>>> rtl/dstl_ctrl.sv
// ----------------------------------------------------------------------------
// dstl_ctrl
// Sequencer for writes and lookups: drives the three bracketing searches,
// the file name scan and the argument count, and owns the result handshake.
// ----------------------------------------------------------------------------
`include "debug_symbol_table_lookup_defines.svh"

module dstl_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 command,
	output logic                 in_stall,
	output logic                 out_valid,
	input  logic                 out_stall,
	input  dstl_pkg::dp_status_t status,
	output dstl_pkg::dp_cmd_t    cmd
);
	import dstl_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE,
		S_START,
		S_B_INIT,
		S_B_LOOP,
		S_B_MCHK,
		S_B_MDAT,
		S_B_END,
		S_B_KCHK,
		S_B_KDAT,
		S_RET,
		S_FUNC_SET,
		S_LINE_SET,
		S_S_CHK,
		S_S_DAT,
		S_A_START,
		S_A_CHK,
		S_A_DAT,
		S_EMIT
	} state_t;

	typedef enum logic [1:0] {
		PH_FILE,
		PH_FUNC,
		PH_LINE
	} phase_t;

	state_t state_q, state_d;
	phase_t phase_q, phase_d;
	logic   out_valid_q;
	logic   emit_go;
	logic   take_lookup;

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	assign emit_go     = (cmd.op == OP_EMIT);
	assign take_lookup = in_valid && !in_stall && (command == CMD_LOOKUP);

	always_comb begin
		state_d = state_q;
		phase_d = phase_q;
		cmd.op  = OP_NONE;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					if (command == CMD_LOOKUP) begin
						cmd.op  = OP_LOAD;
						state_d = S_START;
					end else begin
						cmd.op = OP_WRITE;
					end
				end
			end
			S_START: begin
				if (status.bad_strings) begin
					cmd.op  = OP_BAD;
					state_d = S_EMIT;
				end else begin
					cmd.op  = OP_FILE_INIT;
					phase_d = PH_FILE;
					state_d = S_B_INIT;
				end
			end
			S_B_INIT: begin
				cmd.op  = OP_B_INIT;
				state_d = S_B_LOOP;
			end
			S_B_LOOP: begin
				if (status.l_le_r) begin
					cmd.op  = OP_B_MID;
					state_d = S_B_MCHK;
				end else begin
					state_d = S_B_END;
				end
			end
			S_B_MCHK: begin
				if (status.m_lt_l) begin
					cmd.op  = OP_B_MISS;
					state_d = S_B_LOOP;
				end else begin
					cmd.op  = OP_RD_M;
					state_d = S_B_MDAT;
				end
			end
			S_B_MDAT: begin
				if (status.ty_hit) begin
					cmd.op  = OP_B_HIT;
					state_d = S_B_LOOP;
				end else begin
					cmd.op  = OP_DEC_M;
					state_d = S_B_MCHK;
				end
			end
			S_B_END: begin
				if (!status.hit) begin
					cmd.op  = OP_B_NOHIT;
					state_d = S_RET;
				end else begin
					cmd.op  = OP_K_HI;
					state_d = S_B_KCHK;
				end
			end
			S_B_KCHK: begin
				if (status.k_gt_lo) begin
					cmd.op  = OP_RD_K;
					state_d = S_B_KDAT;
				end else begin
					cmd.op  = OP_K_DONE;
					state_d = S_RET;
				end
			end
			S_B_KDAT: begin
				if (status.ty_hit) begin
					cmd.op  = OP_K_DONE;
					state_d = S_RET;
				end else begin
					cmd.op  = OP_DEC_K;
					state_d = S_B_KCHK;
				end
			end
			S_RET: begin
				unique case (phase_q)
					PH_FILE: begin
						if (status.lo_zero) begin
							cmd.op  = OP_NOFILE;
							state_d = S_EMIT;
						end else begin
							cmd.op  = OP_FUNC_INIT;
							phase_d = PH_FUNC;
							state_d = S_B_INIT;
						end
					end
					PH_FUNC: begin
						if (status.lo_le_hi) begin
							cmd.op  = OP_FUNC_RD;
							state_d = S_FUNC_SET;
						end else begin
							cmd.op  = OP_NOFUNC;
							phase_d = PH_LINE;
							state_d = S_B_INIT;
						end
					end
					default: begin
						if (!status.lo_le_hi) begin
							cmd.op  = OP_NOLINE;
							state_d = S_EMIT;
						end else begin
							cmd.op  = OP_LINE_RD;
							state_d = S_LINE_SET;
						end
					end
				endcase
			end
			S_FUNC_SET: begin
				cmd.op  = OP_FUNC_SET;
				phase_d = PH_LINE;
				state_d = S_B_INIT;
			end
			S_LINE_SET: begin
				cmd.op  = OP_LINE_SET;
				state_d = S_S_CHK;
			end
			// walk back to the file name entry
			S_S_CHK: begin
				if (status.k_ge_lfile) begin
					cmd.op  = OP_RD_K;
					state_d = S_S_DAT;
				end else begin
					state_d = S_A_START;
				end
			end
			S_S_DAT: begin
				if (status.file_mark) begin
					cmd.op  = OP_FILE_SET;
					state_d = S_A_START;
				end else begin
					cmd.op  = OP_DEC_K;
					state_d = S_S_CHK;
				end
			end
			S_A_START: begin
				if (status.fun_lt) begin
					cmd.op  = OP_ARG_INIT;
					state_d = S_A_CHK;
				end else begin
					state_d = S_EMIT;
				end
			end
			S_A_CHK: begin
				if (status.k_lt_rfun) begin
					cmd.op  = OP_RD_K;
					state_d = S_A_DAT;
				end else begin
					state_d = S_EMIT;
				end
			end
			S_A_DAT: begin
				if (status.is_param) begin
					cmd.op  = OP_ARG_INC;
					state_d = S_A_CHK;
				end else begin
					state_d = S_EMIT;
				end
			end
			S_EMIT: begin
				if (!out_valid_q || !out_stall) begin
					cmd.op  = OP_EMIT;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			phase_q     <= PH_FILE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
			if (cmd.op == OP_EMIT) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	`DSTL_ASSERT(a_emit_no_overwrite, emit_go |-> (!out_valid_q || !out_stall), "result overwritten")
	`DSTL_ASSERT(a_emit_shows, emit_go |=> (out_valid_q && state_q == S_IDLE), "item not shown")
	`DSTL_ASSERT(a_lookup_starts, take_lookup |=> (state_q == S_START), "lookup not started")
	`DSTL_ASSERT_ALWAYS(a_reset_idle, !arst_n |=> (!in_stall && !out_valid_q), "not idle in reset")

endmodule

>>> rtl/dstl_datapath.sv
// ----------------------------------------------------------------------------
// dstl_datapath
// Symbol table memory, configuration registers, search indexes and result
// registers, stepped by the controller one operation per cycle.
// ----------------------------------------------------------------------------
module dstl_datapath #(
	parameter int TABLE_DEPTH   = 4096,
	parameter int ADDRESS_WIDTH = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	input  logic [1:0]           cfg_index,
	input  logic [31:0]          cfg_data,
	input  logic [11:0]          entry_index,
	input  logic [7:0]           entry_type,
	input  logic [31:0]          entry_value,
	input  logic [31:0]          entry_string_offset,
	input  logic [15:0]          entry_desc,
	input  logic [31:0]          lookup_address,
	input  dstl_pkg::dp_cmd_t    cmd,
	output dstl_pkg::dp_status_t status,
	output logic [1:0]           status_code,
	output logic                 file_found,
	output logic [31:0]          file_string_offset,
	output logic [15:0]          line_number,
	output logic                 function_found,
	output logic                 function_name_valid,
	output logic [31:0]          function_name_offset,
	output logic [31:0]          function_address,
	output logic [11:0]          argument_count
);
	import dstl_pkg::*;

	localparam int IW = $clog2(TABLE_DEPTH);
	localparam int XW = IW + 2;
	localparam int AW = ADDRESS_WIDTH;
	localparam logic [31:0] DEPTH32 = 32'(TABLE_DEPTH);

	logic [7:0]    type_mem  [TABLE_DEPTH];
	logic [AW-1:0] value_mem [TABLE_DEPTH];
	logic [31:0]   soff_mem  [TABLE_DEPTH];
	logic [15:0]   desc_mem  [TABLE_DEPTH];

	logic [7:0]    rd_type_q;
	logic [AW-1:0] rd_value_q;
	logic [31:0]   rd_soff_q;
	logic [15:0]   rd_desc_q;

	logic [12:0] entry_count_q;
	logic [31:0] string_size_q;
	logic        strings_valid_q;

	logic signed [XW-1:0] lo_q, hi_q, l_q, r_q, mid_q, m_q, k_q;
	logic signed [XW-1:0] lfile_q, rfile_q, lfun_q, rfun_q;
	logic signed [XW-1:0] count_x, mid_w;
	logic                 hit_q;
	logic [7:0]           ty_q;
	logic [AW-1:0]        key_q, baddr_q;

	lookup_status_t res_status_q;
	logic           res_file_found_q, res_fn_found_q, res_name_valid_q;
	logic [31:0]    res_file_off_q, res_name_off_q;
	logic [15:0]    res_line_q;
	logic [AW-1:0]  res_fn_addr_q;
	logic [11:0]    res_nargs_q;

	logic [1:0]  out_status_q;
	logic        out_file_found_q, out_fn_found_q, out_name_valid_q;
	logic [31:0] out_file_off_q, out_name_off_q, out_fn_addr_q;
	logic [15:0] out_line_q;
	logic [11:0] out_nargs_q;

	logic [31:0]   count_w;
	logic [IW-1:0] raddr;
	logic          rd_en;

	assign count_w = ({19'd0, entry_count_q} > DEPTH32) ? DEPTH32 : {19'd0, entry_count_q};
	assign count_x = $signed(XW'(count_w));
	assign mid_w   = l_q + ((r_q - l_q) >>> 1);

	always_comb begin
		rd_en = 1'b1;
		case (cmd.op)
			OP_RD_M:    raddr = m_q[IW-1:0];
			OP_RD_K:    raddr = k_q[IW-1:0];
			OP_FUNC_RD: raddr = lo_q[IW-1:0];
			OP_LINE_RD: raddr = hi_q[IW-1:0];
			default: begin
				raddr = m_q[IW-1:0];
				rd_en = 1'b0;
			end
		endcase
	end

	assign status.bad_strings = (string_size_q == 32'd0) || !strings_valid_q;
	assign status.l_le_r      = (l_q <= r_q);
	assign status.m_lt_l      = (m_q < l_q);
	assign status.ty_hit      = (rd_type_q == ty_q);
	assign status.hit         = hit_q;
	assign status.k_gt_lo     = (k_q > lo_q);
	assign status.lo_zero     = (lo_q == '0);
	assign status.lo_le_hi    = (lo_q <= hi_q);
	assign status.k_ge_lfile  = (k_q >= lfile_q);
	assign status.file_mark   = (rd_type_q == TY_INCL) ||
		((rd_type_q == TY_FILE) && (rd_value_q != '0));
	assign status.fun_lt      = (lfun_q < rfun_q);
	assign status.k_lt_rfun   = (k_q < rfun_q);
	assign status.is_param    = (rd_type_q == TY_PARAM);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q   <= '0;
			string_size_q   <= '0;
			strings_valid_q <= 1'b0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_ENTRY_COUNT:   entry_count_q   <= cfg_data[12:0];
				REG_STRING_SIZE:   string_size_q   <= cfg_data;
				REG_STRINGS_VALID: strings_valid_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_WRITE && {20'd0, entry_index} < DEPTH32) begin
			type_mem[IW'(entry_index)]  <= entry_type;
			value_mem[IW'(entry_index)] <= AW'(entry_value);
			soff_mem[IW'(entry_index)]  <= entry_string_offset;
			desc_mem[IW'(entry_index)]  <= entry_desc;
		end
		if (rd_en) begin
			rd_type_q  <= type_mem[raddr];
			rd_value_q <= value_mem[raddr];
			rd_soff_q  <= soff_mem[raddr];
			rd_desc_q  <= desc_mem[raddr];
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				key_q            <= AW'(lookup_address);
				res_status_q     <= LS_FOUND;
				res_file_found_q <= 1'b0;
				res_file_off_q   <= '0;
				res_line_q       <= '0;
				res_fn_found_q   <= 1'b0;
				res_name_valid_q <= 1'b0;
				res_name_off_q   <= '0;
				res_fn_addr_q    <= AW'(lookup_address);
				res_nargs_q      <= '0;
			end
			OP_BAD:    res_status_q <= LS_BAD_STRINGS;
			OP_NOFILE: res_status_q <= LS_NO_FILE;
			OP_NOLINE: res_status_q <= LS_NO_LINE;
			OP_FILE_INIT: begin
				lo_q <= '0;
				hi_q <= count_x - XW'(1);
				ty_q <= TY_FILE;
			end
			OP_B_INIT: begin
				l_q     <= lo_q;
				r_q     <= hi_q;
				hit_q   <= 1'b0;
				baddr_q <= key_q;
			end
			OP_B_MID: begin
				mid_q <= mid_w;
				m_q   <= mid_w;
			end
			OP_B_MISS: l_q <= mid_q + XW'(1);
			OP_DEC_M:  m_q <= m_q - XW'(1);
			OP_B_HIT: begin
				hit_q <= 1'b1;
				if (rd_value_q < baddr_q) begin
					lo_q <= m_q;
					l_q  <= mid_q + XW'(1);
				end else if (rd_value_q > baddr_q) begin
					hi_q <= m_q - XW'(1);
					r_q  <= m_q - XW'(1);
				end else begin
					// equal value: keep the entry and move past it
					lo_q    <= m_q;
					l_q     <= m_q;
					baddr_q <= baddr_q + AW'(1);
				end
			end
			OP_B_NOHIT: hi_q <= lo_q - XW'(1);
			OP_K_HI:    k_q  <= hi_q;
			OP_DEC_K:   k_q  <= k_q - XW'(1);
			OP_K_DONE:  lo_q <= k_q;
			OP_FUNC_INIT: begin
				lfile_q <= lo_q;
				rfile_q <= hi_q;
				ty_q    <= TY_FUNC;
			end
			OP_FUNC_RD: begin
				lfun_q <= lo_q;
				rfun_q <= hi_q;
			end
			OP_FUNC_SET: begin
				res_fn_found_q <= 1'b1;
				if (rd_soff_q < string_size_q) begin
					res_name_valid_q <= 1'b1;
					res_name_off_q   <= rd_soff_q;
				end
				res_fn_addr_q <= rd_value_q;
				// line entries are relative to the function start
				key_q <= key_q - rd_value_q;
				ty_q  <= TY_LINE;
			end
			OP_NOFUNC: begin
				lfun_q <= lo_q;
				rfun_q <= hi_q;
				lo_q   <= lfile_q;
				hi_q   <= rfile_q;
				ty_q   <= TY_LINE;
			end
			OP_LINE_RD:  k_q <= lo_q;
			OP_LINE_SET: res_line_q <= rd_desc_q;
			OP_FILE_SET: begin
				if (rd_soff_q < string_size_q) begin
					res_file_found_q <= 1'b1;
					res_file_off_q   <= rd_soff_q;
				end
			end
			OP_ARG_INIT: k_q <= lfun_q + XW'(1);
			OP_ARG_INC: begin
				if (res_nargs_q != '1) begin
					res_nargs_q <= res_nargs_q + 12'd1;
				end
				k_q <= k_q + XW'(1);
			end
			OP_EMIT: begin
				out_status_q     <= res_status_q;
				out_file_found_q <= res_file_found_q;
				out_file_off_q   <= res_file_off_q;
				out_line_q       <= res_line_q;
				out_fn_found_q   <= res_fn_found_q;
				out_name_valid_q <= res_name_valid_q;
				out_name_off_q   <= res_name_off_q;
				out_fn_addr_q    <= 32'(res_fn_addr_q);
				out_nargs_q      <= res_nargs_q;
			end
			default: ;
		endcase
	end

	assign status_code          = out_status_q;
	assign file_found           = out_file_found_q;
	assign file_string_offset   = out_file_off_q;
	assign line_number          = out_line_q;
	assign function_found       = out_fn_found_q;
	assign function_name_valid  = out_name_valid_q;
	assign function_name_offset = out_name_off_q;
	assign function_address     = out_fn_addr_q;
	assign argument_count       = out_nargs_q;

endmodule

>>> rtl/debug_symbol_table_lookup.sv
// ----------------------------------------------------------------------------
// debug_symbol_table_lookup
// Debug symbol table with address to source line lookup.
// ----------------------------------------------------------------------------
// A write item stores one table entry. A lookup item runs three
// type-filtered binary searches (file, function, line), a backward scan for
// the file name entry and a forward count of parameter entries, all through
// a single registered read port of the table memory, so a lookup takes a
// data-dependent number of cycles that grows with the search steps, with
// every entry skipped by a type scan and with every entry walked by the file
// name scan and by the parameter count, about log2(entry_count) steps per
// search. One item is worked at a time; the input is stalled from the accept
// of a lookup until its result is moved to the output register.
// Configuration writes are taken every cycle and belong in idle periods only.
module debug_symbol_table_lookup #(
	parameter int TABLE_DEPTH   = 4096,
	parameter int ADDRESS_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        command,
	input  logic [11:0] entry_index,
	input  logic [7:0]  entry_type,
	input  logic [31:0] entry_value,
	input  logic [31:0] entry_string_offset,
	input  logic [15:0] entry_desc,
	input  logic [31:0] lookup_address,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic        file_found,
	output logic [31:0] file_string_offset,
	output logic [15:0] line_number,
	output logic        function_found,
	output logic        function_name_valid,
	output logic [31:0] function_name_offset,
	output logic [31:0] function_address,
	output logic [11:0] argument_count
);
	import dstl_pkg::*;

	dp_cmd_t    dp_cmd;
	dp_status_t dp_status;

	assign cfg_ready = 1'b1;

	dstl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.command   (command),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (dp_status),
		.cmd       (dp_cmd)
	);

	dstl_datapath #(
		.TABLE_DEPTH   (TABLE_DEPTH),
		.ADDRESS_WIDTH (ADDRESS_WIDTH)
	) u_datapath (
		.clk                  (clk),
		.arst_n               (arst_n),
		.cfg_valid            (cfg_valid),
		.cfg_index            (cfg_index),
		.cfg_data             (cfg_data),
		.entry_index          (entry_index),
		.entry_type           (entry_type),
		.entry_value          (entry_value),
		.entry_string_offset  (entry_string_offset),
		.entry_desc           (entry_desc),
		.lookup_address       (lookup_address),
		.cmd                  (dp_cmd),
		.status               (dp_status),
		.status_code          (status),
		.file_found           (file_found),
		.file_string_offset   (file_string_offset),
		.line_number          (line_number),
		.function_found       (function_found),
		.function_name_valid  (function_name_valid),
		.function_name_offset (function_name_offset),
		.function_address     (function_address),
		.argument_count       (argument_count)
	);

endmodule
